/* rtl/spf_pkg.sv */
`default_nettype none

package spf_pkg;

    localparam int WORD_W  = 32;
    localparam int REG_W   = 31;
    localparam int GAIN_W  = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FENCE_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_DISTANCE = 2'd1;

    localparam logic [REG_W-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [REG_W-1:0] FADE_RESET   = 31'd6554;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 17'd32768;

    // cosine polynomial coefficients, Q28
    localparam logic [31:0] CO1 = 32'd1324675879;
    localparam logic [31:0] CO2 = 32'd1089502240;
    localparam logic [31:0] CO3 = 32'd358431870;
    localparam logic [31:0] CO4 = 32'd63171085;
    localparam logic [31:0] CO5 = 32'd6927485;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [31:0] poly_coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            3'd2:    c = CO4;
            3'd3:    c = CO3;
            3'd4:    c = CO2;
            3'd5:    c = CO1;
            default: c = CO5;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/spf_ifs.sv */
`default_nettype none

interface spf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        last_object;
    modport source (output valid, pos_x, pos_y, pos_z, last_object, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last_object, output ready);
endinterface

interface spf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        was_clamped;
    logic [16:0] fade_gain;
    logic        frame_done;
    modport source (output valid, out_x, out_y, out_z, was_clamped, fade_gain, frame_done,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, was_clamped, fade_gain, frame_done,
                    output ready);
endinterface

interface spf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/spf_mul.sv */
`default_nettype none

module spf_mul
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] prod_reg
);

    // register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

/* rtl/spf_div.sv */
`default_nettype none

module spf_div
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic      [31:0] quo_reg,
    output unit_stat_t       stat
);

    // restoring divide, one quotient bit a cycle; needs dividend[63:32] < divisor
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* rtl/spf_sqrt.sv */
`default_nettype none

module spf_sqrt
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root_reg,
    output unit_stat_t       stat
);

    // digit-by-digit floor root, two radicand bits a cycle
    logic [63:0] rad_reg;
    logic [32:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] cand;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        take;

    assign cand  = {rem_reg, rad_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = cand - trial;
    assign take  = cand >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= take ? diff[32:0] : cand[32:0];
            root_reg <= {root_reg[30:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* rtl/spherical_position_fence.sv */
`default_nettype none
// channel | dir | word
// obj     | in  | pos_x, pos_y, pos_z (Q15.16 signed), last_object
// res     | out | out_x, out_y, out_z, was_clamped, fade_gain (Q1.16), frame_done
// cfg     | in  | index (0 fence_radius, 1 fade_distance), data (low 31 bits kept)
//
// One word at a time: each object takes a root, a clamped object three divides
// more, and a frame's last object (fade distance nonzero) a gain divide plus a
// six-step polynomial on the shared multiplier.
// rst_n clears the sequencer and loads the register reset values; no clearing pass.
// A finished word waits in the output register; obj is taken again meanwhile.

module spherical_position_fence
    import spf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spf_in_if.sink     obj,
    spf_out_if.source  res,
    spf_cfg_if.sink    cfg
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL       = 4'd1;
    localparam logic [3:0] S_SQRT_GO   = 4'd2;
    localparam logic [3:0] S_SQRT_WAIT = 4'd3;
    localparam logic [3:0] S_DMUL      = 4'd4;
    localparam logic [3:0] S_DIV_GO    = 4'd5;
    localparam logic [3:0] S_DIV_WAIT  = 4'd6;
    localparam logic [3:0] S_CLR       = 4'd7;
    localparam logic [3:0] S_GAIN_GO   = 4'd8;
    localparam logic [3:0] S_GAIN_WAIT = 4'd9;
    localparam logic [3:0] S_POLY      = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0]  state_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  axis_reg;
    logic [31:0] mx_reg, my_reg, mz_reg;
    logic [2:0]  neg_reg;
    logic        last_reg;
    logic [63:0] sum_reg;
    logic [63:0] rr_reg;
    logic [31:0] len_reg;
    logic        clamp_reg;
    logic [31:0] sx_reg, sy_reg, sz_reg;
    logic [REG_W-1:0] radius_reg, fade_reg, minc_reg, k_reg;
    logic        hi_reg;
    logic [15:0] q_reg;
    logic [31:0] s_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic        ovalid_reg;
    logic [31:0] ox_reg, oy_reg, oz_reg;
    logic        oclamp_reg;
    logic [GAIN_W-1:0] ogain_reg;
    logic        odone_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic        sq_start, dv_start;
    logic [63:0] dv_dividend;
    logic [31:0] dv_divisor;
    logic [31:0] root_reg, quo_reg;
    unit_stat_t  sq_stat, dv_stat;

    logic [31:0] axis_mag;
    logic [31:0] h_next;
    logic [REG_W-1:0] clr, minc_new, k_new;
    logic [16:0] p;
    logic [33:0] c_raw;
    logic [28:0] c_clip;
    logic [29:0] g_sum;
    logic [GAIN_W-1:0] g;
    logic        load_ok;

    spf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_reg(prod_reg));

    spf_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_reg),
        .root_reg(root_reg), .stat(sq_stat)
    );

    spf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .quo_reg(quo_reg), .stat(dv_stat)
    );

    assign obj.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign axis_mag = (axis_reg == 2'd0) ? mx_reg : ((axis_reg == 2'd1) ? my_reg : mz_reg);
    // Horner step: coefficient minus the truncated previous product
    assign h_next   = poly_coef(cnt_reg) - prod_reg[63:32];

    // clearance, floored at zero, and the running minimum
    assign clr      = ({1'b0, radius_reg} > len_reg) ? (radius_reg - len_reg[REG_W-1:0]) : '0;
    assign minc_new = (clr < minc_reg) ? clr : minc_reg;
    assign k_new    = (minc_new > fade_reg) ? fade_reg : minc_new;

    assign p        = quo_reg[16:0];

    // final polynomial step: clip cosine to 0..2^28 and round to Q1.16
    assign c_raw  = {5'd0, 29'h1000_0000} - {2'b00, prod_reg[63:32]};
    assign c_clip = c_raw[33] ? 29'd0 : c_raw[28:0];
    assign g_sum  = 30'h10000000 + {1'b0, c_clip} + 30'd4096;
    assign g      = g_sum[29:13];

    assign load_ok = !ovalid_reg || res.ready;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                case (cnt_reg)
                    3'd0:    begin mul_a = mx_reg; mul_b = mx_reg; end
                    3'd1:    begin mul_a = my_reg; mul_b = my_reg; end
                    3'd2:    begin mul_a = mz_reg; mul_b = mz_reg; end
                    default: begin mul_a = {1'b0, radius_reg}; mul_b = {1'b0, radius_reg}; end
                endcase
            end
            S_DMUL:
            begin
                mul_a = axis_mag;
                mul_b = {1'b0, radius_reg};
            end
            S_POLY:
            begin
                case (cnt_reg)
                    3'd0:    begin mul_a = {16'd0, q_reg}; mul_b = {16'd0, q_reg}; end
                    3'd1:    begin mul_a = CO5; mul_b = prod_reg[31:0]; end
                    default: begin mul_a = h_next; mul_b = s_reg; end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        sq_start    = (state_reg == S_SQRT_GO);
        dv_start    = (state_reg == S_DIV_GO) || (state_reg == S_GAIN_GO);
        if (state_reg == S_GAIN_GO)
        begin
            dv_dividend = {17'd0, k_reg, 16'd0};
            dv_divisor  = {1'b0, fade_reg};
        end
        else
        begin
            dv_dividend = prod_reg;
            dv_divisor  = len_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (obj.valid)
                begin
                    mx_reg   <= obj.pos_x[31] ? (~obj.pos_x + 32'd1) : obj.pos_x;
                    my_reg   <= obj.pos_y[31] ? (~obj.pos_y + 32'd1) : obj.pos_y;
                    mz_reg   <= obj.pos_z[31] ? (~obj.pos_z + 32'd1) : obj.pos_z;
                    neg_reg  <= {obj.pos_z[31], obj.pos_y[31], obj.pos_x[31]};
                    last_reg <= obj.last_object;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == 3'd1)
                    sum_reg <= prod_reg;
                else if (cnt_reg == 3'd2 || cnt_reg == 3'd3)
                    sum_reg <= sum_reg + prod_reg;
                else if (cnt_reg == 3'd4)
                    rr_reg <= prod_reg;
            end
            S_SQRT_GO:
            begin
                clamp_reg <= sum_reg > rr_reg;
            end
            S_SQRT_WAIT:
            begin
                if (sq_stat.done)
                begin
                    len_reg <= root_reg;
                    sx_reg  <= mx_reg;
                    sy_reg  <= my_reg;
                    sz_reg  <= mz_reg;
                end
            end
            S_DIV_WAIT:
            begin
                if (dv_stat.done)
                begin
                    if (axis_reg == 2'd0)
                        sx_reg <= quo_reg;
                    else if (axis_reg == 2'd1)
                        sy_reg <= quo_reg;
                    else
                        sz_reg <= quo_reg;
                end
            end
            S_CLR:
            begin
                k_reg <= k_new;
                if (!last_reg)
                    gain_reg <= '0;
                else if (fade_reg == '0)
                    gain_reg <= GAIN_ONE;
            end
            S_GAIN_WAIT:
            begin
                if (dv_stat.done)
                begin
                    hi_reg <= p > GAIN_HALF;
                    q_reg  <= (p > GAIN_HALF) ? 16'(GAIN_ONE - p) : p[15:0];
                end
            end
            S_POLY:
            begin
                if (cnt_reg == 3'd1)
                    s_reg <= prod_reg[31:0];
                if (cnt_reg == 3'd6)
                    gain_reg <= hi_reg ? (GAIN_ONE - g) : g;
            end
            S_DONE:
            begin
                if (load_ok)
                begin
                    ox_reg     <= neg_reg[0] ? (~sx_reg + 32'd1) : sx_reg;
                    oy_reg     <= neg_reg[1] ? (~sy_reg + 32'd1) : sy_reg;
                    oz_reg     <= neg_reg[2] ? (~sz_reg + 32'd1) : sz_reg;
                    oclamp_reg <= clamp_reg;
                    ogain_reg  <= gain_reg;
                    odone_reg  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, registers, running minimum, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            axis_reg   <= '0;
            radius_reg <= RADIUS_RESET;
            fade_reg   <= FADE_RESET;
            minc_reg   <= FADE_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == CFG_FENCE_RADIUS)
                    radius_reg <= cfg.data[REG_W-1:0];
                else if (cfg.index == CFG_FADE_DISTANCE)
                    fade_reg <= cfg.data[REG_W-1:0];
            end

            if (state_reg == S_DONE && load_ok)
                ovalid_reg <= 1'b1;
            else if (res.ready)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (obj.valid)
                    begin
                        state_reg <= S_MUL;
                        cnt_reg   <= '0;
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                        state_reg <= S_SQRT_GO;
                end
                S_SQRT_GO:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sq_stat.done)
                    begin
                        axis_reg  <= '0;
                        state_reg <= clamp_reg ? S_DMUL : S_CLR;
                    end
                end
                S_DMUL:
                begin
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (dv_stat.done)
                    begin
                        if (axis_reg == 2'd2)
                            state_reg <= S_CLR;
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DMUL;
                        end
                    end
                end
                S_CLR:
                begin
                    // reload the minimum at the end of a frame
                    minc_reg <= last_reg ? fade_reg : minc_new;
                    if (last_reg && fade_reg != '0)
                        state_reg <= S_GAIN_GO;
                    else
                        state_reg <= S_DONE;
                end
                S_GAIN_GO:
                begin
                    state_reg <= S_GAIN_WAIT;
                end
                S_GAIN_WAIT:
                begin
                    if (dv_stat.done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_POLY;
                    end
                end
                S_POLY:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load_ok)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid       = ovalid_reg;
    assign res.out_x       = ox_reg;
    assign res.out_y       = oy_reg;
    assign res.out_z       = oz_reg;
    assign res.was_clamped = oclamp_reg;
    assign res.fade_gain   = ogain_reg;
    assign res.frame_done  = odone_reg;

`ifndef SYNTHESIS
    // hold off new words while one is at work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        obj.valid && obj.ready |=> !obj.ready)
        else $error("obj taken again right after accept");

    // gain only on a frame's last word
    a_gain_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !odone_reg |-> ogain_reg == '0)
        else $error("gain without frame_done");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> ogain_reg <= GAIN_ONE)
        else $error("gain above one");

    // the shared units never run together
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_stat.busy && dv_stat.busy))
        else $error("root and divider busy together");
`endif

endmodule

`default_nettype wire

/* tb/spf_checker.sv */
`default_nettype none

module spf_checker
    import spf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    spf_in_if         obj,
    spf_out_if        res,
    spf_cfg_if        cfg,
    output int        fail_count,
    output int        pending,
    output int        word_count,
    output int        clamp_count,
    output int        frame_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        logic              clamped;
        logic [GAIN_W-1:0] gain;
        logic              done;
    } fence_word_t;

    fence_word_t      expected_words[$];
    logic [REG_W-1:0] radius;
    logic [REG_W-1:0] fade;
    logic [REG_W-1:0] min_clearance;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // raised cosine over the first half turn, q in 0..32768
    function automatic logic [63:0] half_cosine(input logic [63:0] q);
        logic [63:0] s;
        logic [63:0] h;
        longint      c;
        s = q * q;
        h = 64'(CO5);
        h = 64'(CO4) - ((h * s) >> 32);
        h = 64'(CO3) - ((h * s) >> 32);
        h = 64'(CO2) - ((h * s) >> 32);
        h = 64'(CO1) - ((h * s) >> 32);
        c = (longint'(1) << 28) - longint'((h * s) >> 32);
        if (c < 0) c = 0;
        if (c > (longint'(1) << 28)) c = longint'(1) << 28;
        return ((64'd1 << 28) + 64'(c) + (64'd1 << 12)) >> 13;
    endfunction

    function automatic logic [GAIN_W-1:0] fade_gain_of(input logic [63:0] k,
                                                       input logic [63:0] f);
        logic [63:0] p;
        if (f == 0) return GAIN_ONE;
        if (k > f) k = f;
        p = (k << 16) / f;
        if (p <= 64'(GAIN_HALF)) return GAIN_W'(half_cosine(p));
        return GAIN_W'(64'(GAIN_ONE) - half_cosine(64'(GAIN_ONE) - p));
    endfunction

    task automatic predict_word();
        logic [63:0] mag[3];
        logic        neg[3];
        logic [31:0] coord[3];
        logic [31:0] outc[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] clr;
        logic [63:0] m;
        logic [63:0] r;
        logic        clamp;
        fence_word_t w;
        coord[0] = obj.pos_x;
        coord[1] = obj.pos_y;
        coord[2] = obj.pos_z;
        sum = 0;
        r = 64'(radius);
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = coord[i][31];
            mag[i] = neg[i] ? 64'(32'(-coord[i])) : 64'(coord[i]);
            sum = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        clamp = sum > r * r;
        for (int i = 0; i < 3; i++)
        begin
            m = mag[i];
            if (clamp) m = (m * r) / len;
            outc[i] = neg[i] ? 32'(-m) : 32'(m);
        end
        clr = (r > len) ? r - len : 0;
        if (clr < 64'(min_clearance)) min_clearance = REG_W'(clr);
        w.x = outc[0];
        w.y = outc[1];
        w.z = outc[2];
        w.clamped = clamp;
        w.done = obj.last_object;
        if (obj.last_object)
        begin
            w.gain = fade_gain_of(64'(min_clearance), 64'(fade));
            min_clearance = fade;
        end
        else
            w.gain = '0;
        expected_words.push_back(w);
    endtask

    task automatic check_word();
        fence_word_t w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected result word x=%h y=%h z=%h", $time,
                     res.out_x, res.out_y, res.out_z);
            fail_count++;
            return;
        end
        w = expected_words.pop_front();
        word_count++;
        if (w.clamped) clamp_count++;
        if (w.done) frame_count++;
        if (res.out_x !== w.x || res.out_y !== w.y || res.out_z !== w.z ||
            res.was_clamped !== w.clamped || res.fade_gain !== w.gain ||
            res.frame_done !== w.done)
        begin
            $display("%0t: mismatch expected x=%h y=%h z=%h clamp=%b gain=%0d done=%b",
                     $time, w.x, w.y, w.z, w.clamped, w.gain, w.done);
            $display("%0t:          actual   x=%h y=%h z=%h clamp=%b gain=%0d done=%b",
                     $time, res.out_x, res.out_y, res.out_z, res.was_clamped,
                     res.fade_gain, res.frame_done);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius = RADIUS_RESET;
            fade = FADE_RESET;
            min_clearance = FADE_RESET;
            expected_words.delete();
            fail_count = 0;
            word_count = 0;
            clamp_count = 0;
            frame_count = 0;
            pending = 0;
        end
        else
        begin
            if (res.valid && res.ready) check_word();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_FENCE_RADIUS) radius = cfg.data[REG_W-1:0];
                else if (cfg.index == CFG_FADE_DISTANCE) fade = cfg.data[REG_W-1:0];
            end
            if (obj.valid && obj.ready) predict_word();
            pending = expected_words.size();
        end
    end
endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
    import spf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the two registers; the block must drop these writes
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   word_count;
    int   clamp_count;
    int   frame_count;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic [REG_W-1:0] cur_radius;

    spf_in_if  obj();
    spf_out_if res();
    spf_cfg_if cfg();

    spherical_position_fence uut (
        .clk   (clk),
        .rst_n (rst_n),
        .obj   (obj),
        .res   (res),
        .cfg   (cfg)
    );

    spf_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .obj         (obj),
        .res         (res),
        .cfg         (cfg),
        .fail_count  (fail_count),
        .pending     (pending),
        .word_count  (word_count),
        .clamp_count (clamp_count),
        .frame_count (frame_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cap the whole run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("spherical_position_fence regression: fail");
                $finish;
            end
        end
    end

    // result side: stall at random, rate set by the current phase
    always @(negedge clk)
    begin
        if (rst_n) res.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // push one position word; hold valid across back-to-back words
    task automatic send_pos(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            obj.valid = 1'b0;
            @(negedge clk);
        end
        obj.valid = 1'b1;
        obj.pos_x = x;
        obj.pos_y = y;
        obj.pos_z = z;
        obj.last_object = last;
        @(posedge clk);
        while (!obj.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic drain();
        obj.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // write a register; only called with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
        if (idx == CFG_FENCE_RADIUS) cur_radius = val[REG_W-1:0];
    endtask

    // coordinate: mostly scaled to the fence radius so both sides of the
    // sphere get hit, the rest full-range words
    function automatic logic [31:0] rand_coord();
        logic [31:0] bound;
        logic [31:0] m;
        if ($urandom_range(3) == 0) return $urandom;
        bound = 32'(cur_radius) >> $urandom_range(2);
        m = $urandom_range(bound);
        return $urandom_range(1) ? -m : m;
    endfunction

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
        begin
            // advance the idling pattern through the three thirds of the run
            if (word_count < RANDOM_WORDS / 3)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 69;
            end
            else if (word_count < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pos(rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(3) == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        obj.valid = 1'b0;
        obj.pos_x = '0;
        obj.pos_y = '0;
        obj.pos_z = '0;
        obj.last_object = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_FENCE_RADIUS;
        cfg.data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cur_radius = RADIUS_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers first
        send_pos(32'h0, 32'h0, 32'h0, 1'b1);                   // origin, full clearance
        send_pos(32'h0001_0000, 32'h0, 32'h0, 1'b1);           // exactly on the sphere
        send_pos(32'h0001_0001, 32'h0, 32'h0, 1'b0);           // just outside
        send_pos(32'h0, 32'hFFFF_0000, 32'h0, 1'b1);           // negative axis, on sphere
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pos(32'h8000_0000, 32'h0, 32'h1, 1'b1);
        send_pos(32'h0000_C000, 32'h0, 32'h0, 1'b1);           // clearance wider than the fade distance
        // writes to unused indexes must leave both registers alone
        write_reg(CFG_SPARE_A, 32'h0000_1234);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        send_pos(32'h0000_F000, 32'h0, 32'h0, 1'b1);
        // shrink the fade distance in the middle of a frame
        send_pos(32'h0000_8000, 32'h0, 32'h0, 1'b0);
        write_reg(CFG_FADE_DISTANCE, 32'h0000_0100);
        send_pos(32'h0, 32'h0, 32'h0, 1'b1);
        // zero fade distance, written with the top bit set to check masking
        write_reg(CFG_FADE_DISTANCE, 32'h8000_0000);
        send_pos(32'h0000_FF00, 32'h0, 32'h0, 1'b1);
        send_pos(32'h0, 32'h0, 32'h0, 1'b1);
        // zero radius: everything but the origin is clamped
        write_reg(CFG_FENCE_RADIUS, 32'h0);
        write_reg(CFG_FADE_DISTANCE, 32'h0000_0001);
        send_pos(32'h0, 32'h0, 32'h0, 1'b1);
        send_pos(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b1);
        write_reg(CFG_FENCE_RADIUS, 32'hFFFF_FFFF);
        write_reg(CFG_FADE_DISTANCE, 32'h7FFF_FFFF);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pos(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
        drain();

        // random: sweep settings, extremes included
        write_reg(CFG_FENCE_RADIUS, 32'(RADIUS_RESET));
        write_reg(CFG_FADE_DISTANCE, 32'(FADE_RESET));
        random_burst(110);
        write_reg(CFG_FENCE_RADIUS, 32'h7FFF_FFFF);
        write_reg(CFG_FADE_DISTANCE, 32'h7FFF_FFFF);
        random_burst(110);
        write_reg(CFG_FENCE_RADIUS, 32'h0010_0000);
        write_reg(CFG_FADE_DISTANCE, 32'h0000_0001);
        random_burst(100);
        // hold off until everything is back, then carry on
        drain();
        random_burst(10);
        write_reg(CFG_FENCE_RADIUS, 32'h0003_0000);
        write_reg(CFG_FADE_DISTANCE, 32'h0004_0000);
        random_burst(110);
        write_reg(CFG_FENCE_RADIUS, 32'h0);
        write_reg(CFG_FADE_DISTANCE, 32'h0000_8000);
        random_burst(50);
        write_reg(CFG_FENCE_RADIUS, 32'h4000_0000);
        write_reg(CFG_FADE_DISTANCE, 32'h1000_0000);
        random_burst(160);

        drain();
        repeat (300) @(negedge clk);
        $display("covered %0d position words, %0d clamped, %0d frames closed",
                 word_count, clamp_count, frame_count);
        $display("radius and fade swept from zero to full scale, with stalls on both sides");
        if (fail_count == 0 && pending == 0)
            $display("spherical_position_fence regression: pass");
        else
            $display("spherical_position_fence regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
